@@ hw/rtl/tcce_pkg.sv @@
// tcce_pkg: shared types and constants of the text console character engine
// used by tcce_seq and text_console_char_engine_unit; no dependencies
package tcce_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  // item modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_ATTR    = 2'd2;

  // control codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [COL_W-1:0]  RESET_COLS = 7'd80;
  localparam logic [ROW_W-1:0]  RESET_ROWS = 5'd25;
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  typedef struct packed {
    logic [COL_W-1:0]  columns;
    logic [ROW_W-1:0]  rows;
    logic [CHAR_W-1:0] attr;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic              scrolled;
  } res_t;

endpackage

@@ hw/rtl/tcce_cell_mem.sv @@
// tcce_cell_mem: single-port-write, single-port-read cell store
// read data registered; no dependencies
module tcce_cell_mem #(
  parameter int Depth = 2000,
  parameter int AddrW = 11,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tcce_seq.sv @@
// tcce_seq: item sequencer with cursor, glyph writes, scroll copy and clear sweeps
// depends on tcce_pkg; drives the ports of tcce_cell_mem
module tcce_seq #(
  parameter int MaxCols  = 80,
  parameter int MaxRows  = 25,
  parameter int TabWidth = 8,
  parameter int AddrW    = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcce_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcce_pkg::IDX_W-1:0]  cell_index_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output tcce_pkg::res_t              res_o,
  output logic                        mem_we_o,
  output logic [AddrW-1:0]            mem_waddr_o,
  output logic [tcce_pkg::CELL_W-1:0] mem_wdata_o,
  output logic [AddrW-1:0]            mem_raddr_o,
  input  logic [tcce_pkg::CELL_W-1:0] mem_rdata_i
);
  import tcce_pkg::*;

  localparam int CellCount = MaxCols * MaxRows;
  localparam int CW        = $clog2(CellCount + 1);
  localparam int GW        = $clog2(TabWidth + 1);
  localparam int XW        = (CW > IDX_W) ? CW : IDX_W;
  localparam int TabN      = 1 << COL_W;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_GLYPH,
    ST_SCR_CP,
    ST_SCR_BL,
    ST_CLEAR,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [1:0]          mode_q, mode_d;
  logic [CHAR_W-1:0]   ch_q, ch_d;
  logic [IDX_W-1:0]    cidx_q, cidx_d;
  logic [CHAR_W-1:0]   gch_q, gch_d;
  logic [GW-1:0]       cnt_q, cnt_d;
  logic                scr_q, scr_d;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic                cp_v_q, cp_v_d;
  logic [AddrW-1:0]    cp_wa_q, cp_wa_d;
  logic                rd_ok_q, rd_ok_d;
  logic [CELL_W-1:0]   cell_q, cell_d;

  logic [COL_W-1:0]    nc, col_s;
  logic [ROW_W-1:0]    nr, row_s;
  logic [CW-1:0]       tot, lin;
  logic [COL_W:0]      col_nx;
  logic [ROW_W:0]      row_nx;
  logic                col_last, row_last, rd_in;
  logic [CELL_W-1:0]   blank;
  logic [GW-1:0]       tab_gap [TabN];

  for (genvar g = 0; g < TabN; g++) begin : g_tab
    assign tab_gap[g] = GW'(TabWidth - (g % TabWidth));
  end

  // geometry in use
  always_comb begin
    if (cfg_i.columns == '0) begin
      nc = COL_W'(1);
    end else if (int'(cfg_i.columns) > MaxCols) begin
      nc = COL_W'(MaxCols);
    end else begin
      nc = cfg_i.columns;
    end
    if (cfg_i.rows == '0) begin
      nr = ROW_W'(1);
    end else if (int'(cfg_i.rows) > MaxRows) begin
      nr = ROW_W'(MaxRows);
    end else begin
      nr = cfg_i.rows;
    end
  end

  assign col_s    = (col_q >= nc) ? COL_W'(nc - 1'b1) : col_q;
  assign row_s    = (row_q >= nr) ? ROW_W'(nr - 1'b1) : row_q;
  assign tot      = CW'(CW'(nc) * CW'(nr));
  assign lin      = CW'(CW'(row_q) * CW'(nc)) + CW'(col_q);
  assign col_nx   = (COL_W+1)'(col_q) + 1'b1;
  assign row_nx   = (ROW_W+1)'(row_q) + 1'b1;
  assign col_last = col_nx >= (COL_W+1)'(nc);
  assign row_last = row_nx >= (ROW_W+1)'(nr);
  assign rd_in    = XW'(cidx_q) < XW'(tot);
  assign blank    = {cfg_i.attr, CH_SPACE};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o.col       = col_q;
    res_o.row       = row_q;
    res_o.idx       = IDX_W'(lin);
    res_o.cell_char = cell_q[CHAR_W-1:0];
    res_o.cell_attr = cell_q[CELL_W-1:CHAR_W];
    res_o.scrolled  = scr_q;
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    mode_d  = mode_q;
    ch_d    = ch_q;
    cidx_d  = cidx_q;
    gch_d   = gch_q;
    cnt_d   = cnt_q;
    scr_d   = scr_q;
    ptr_d   = ptr_q;
    cp_v_d  = 1'b0;
    cp_wa_d = cp_wa_q;
    rd_ok_d = rd_ok_q;
    cell_d  = cell_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = blank;
    mem_raddr_o = '0;
    unique case (state_q)
      ST_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AddrW-1:0];
        mem_wdata_o = RESET_CELL;
        ptr_d       = ptr_q + 1'b1;
        if (ptr_q == CW'(CellCount - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          col_d   = col_s;
          row_d   = row_s;
          mode_d  = mode_i;
          ch_d    = char_code_i;
          cidx_d  = cell_index_i;
          scr_d   = 1'b0;
          cell_d  = '0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (mode_q)
          MODE_PUT: begin
            case (ch_q)
              CH_LF: begin
                col_d = '0;
                cnt_d = '0;
                if (row_last) begin
                  scr_d   = 1'b1;
                  ptr_d   = CW'(nc);
                  state_d = ST_SCR_CP;
                end else begin
                  row_d   = row_q + 1'b1;
                  state_d = ST_DONE;
                end
              end
              CH_CR: begin
                col_d   = '0;
                state_d = ST_DONE;
              end
              CH_TAB: begin
                cnt_d   = tab_gap[col_q];
                gch_d   = CH_SPACE;
                state_d = ST_GLYPH;
              end
              CH_BS: begin
                if (col_q != '0) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = AddrW'(lin - 1'b1);
                  col_d       = col_q - 1'b1;
                end
                state_d = ST_DONE;
              end
              default: begin
                cnt_d   = GW'(1);
                gch_d   = ch_q;
                state_d = ST_GLYPH;
              end
            endcase
          end
          MODE_READ: begin
            rd_ok_d     = rd_in;
            mem_raddr_o = rd_in ? AddrW'(cidx_q) : '0;
            state_d     = ST_RD_WAIT;
          end
          MODE_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            ptr_d   = '0;
            state_d = ST_CLEAR;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_GLYPH: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(lin);
        mem_wdata_o = {cfg_i.attr, gch_q};
        cnt_d       = cnt_q - 1'b1;
        state_d     = (cnt_q == GW'(1)) ? ST_DONE : ST_GLYPH;
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            scr_d   = 1'b1;
            ptr_d   = CW'(nc);
            state_d = ST_SCR_CP;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_SCR_CP: begin
        // read one row below, write it back in the next cycle
        if (cp_v_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cp_wa_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (ptr_q < tot) begin
          mem_raddr_o = ptr_q[AddrW-1:0];
          cp_v_d      = 1'b1;
          cp_wa_d     = AddrW'(ptr_q - CW'(nc));
          ptr_d       = ptr_q + 1'b1;
        end else begin
          ptr_d   = tot - CW'(nc);
          state_d = ST_SCR_BL;
        end
      end
      ST_SCR_BL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AddrW-1:0];
        ptr_d       = ptr_q + 1'b1;
        if (CW'(ptr_q + 1'b1) == tot) begin
          col_d   = '0;
          row_d   = ROW_W'(nr - 1'b1);
          state_d = (cnt_q != '0) ? ST_GLYPH : ST_DONE;
        end
      end
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AddrW-1:0];
        ptr_d       = ptr_q + 1'b1;
        if (CW'(ptr_q + 1'b1) == tot) begin
          state_d = ST_DONE;
        end
      end
      ST_RD_WAIT: begin
        if (rd_ok_q) begin
          cell_d = mem_rdata_i;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      col_q   <= '0;
      row_q   <= '0;
      mode_q  <= '0;
      ch_q    <= '0;
      cidx_q  <= '0;
      gch_q   <= '0;
      cnt_q   <= '0;
      scr_q   <= 1'b0;
      ptr_q   <= '0;
      cp_v_q  <= 1'b0;
      cp_wa_q <= '0;
      rd_ok_q <= 1'b0;
      cell_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      mode_q  <= mode_d;
      ch_q    <= ch_d;
      cidx_q  <= cidx_d;
      gch_q   <= gch_d;
      cnt_q   <= cnt_d;
      scr_q   <= scr_d;
      ptr_q   <= ptr_d;
      cp_v_q  <= cp_v_d;
      cp_wa_q <= cp_wa_d;
      rd_ok_q <= rd_ok_d;
      cell_q  <= cell_d;
    end
  end

endmodule

@@ hw/rtl/text_console_char_engine_unit.sv @@
// Text console character engine: one item in, one result out. After reset the
// cell store is swept to a space with attribute 0x07, one cell a cycle, during
// which no item is taken; register writes are accepted at any time. A newline
// or glyph that leaves the bottom row adds a scroll; the single write and read
// port of the cell memory paces all of this work.
// Results wait in an output register, so a result that is not yet taken holds
// up the next item only once that item is finished.
// depends on tcce_pkg, tcce_seq and tcce_cell_mem
module text_console_char_engine_unit #(
  parameter int MAX_COLS  = 80,
  parameter int MAX_ROWS  = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcce_pkg::IDX_W-1:0]  cell_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcce_pkg::COL_W-1:0]  out_col_o,
  output logic [tcce_pkg::ROW_W-1:0]  out_row_o,
  output logic [tcce_pkg::IDX_W-1:0]  cursor_index_o,
  output logic [tcce_pkg::CHAR_W-1:0] cell_char_o,
  output logic [tcce_pkg::CHAR_W-1:0] cell_attr_o,
  output logic                        scrolled_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [tcce_pkg::CHAR_W-1:0] cfg_data_i
);
  import tcce_pkg::*;

  localparam int CellCount = MAX_COLS * MAX_ROWS;
  localparam int AW        = $clog2(CellCount);

  cfg_t             cfg_q;
  res_t             res, out_q;
  logic             out_valid_q;
  logic             res_valid, res_ready;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns <= RESET_COLS;
      cfg_q.rows    <= RESET_ROWS;
      cfg_q.attr    <= RESET_ATTR;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLUMNS: cfg_q.columns <= cfg_data_i[COL_W-1:0];
        CFG_ROWS:    cfg_q.rows    <= cfg_data_i[ROW_W-1:0];
        CFG_ATTR:    cfg_q.attr    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcce_seq #(
    .MaxCols  (MAX_COLS),
    .MaxRows  (MAX_ROWS),
    .TabWidth (TAB_WIDTH),
    .AddrW    (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tcce_cell_mem #(
    .Depth (CellCount),
    .AddrW (AW),
    .DataW (CELL_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
      if (res_valid && res_ready) begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_col_o      = out_q.col;
  assign out_row_o      = out_q.row;
  assign cursor_index_o = out_q.idx;
  assign cell_char_o    = out_q.cell_char;
  assign cell_attr_o    = out_q.cell_attr;
  assign scrolled_o     = out_q.scrolled;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine still ready after taking an item");

  a_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_col_o) < MAX_COLS)
    else $error("cursor column beyond store width");

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_row_o) < MAX_ROWS)
    else $error("cursor row beyond store height");

  a_waddr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> int'(mem_waddr) < CellCount)
    else $error("cell write outside the store");

endmodule

@@ verif/text_console_char_engine_unit_tb.sv @@
// text_console_char_engine_unit_tb: self-checking bench for the text console engine; a
// cycle-free model of the cell store and cursor predicts every result. Depends on tcce_pkg
// and text_console_char_engine_unit only.
module text_console_char_engine_unit_tb;
  import tcce_pkg::*;

  localparam int MAX_COLS       = 80;
  localparam int MAX_ROWS       = 25;
  localparam int TAB_W          = 8;
  localparam int CELLS          = MAX_COLS * MAX_ROWS;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 64;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 110;
  localparam int STALL_ITEMS    = 16;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i       = '0;
  logic [CHAR_W-1:0]  char_code_i  = '0;
  logic [IDX_W-1:0]   cell_index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [COL_W-1:0]   out_col_o;
  logic [ROW_W-1:0]   out_row_o;
  logic [IDX_W-1:0]   cursor_index_o;
  logic [CHAR_W-1:0]  cell_char_o;
  logic [CHAR_W-1:0]  cell_attr_o;
  logic               scrolled_o;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i  = '0;
  logic [CHAR_W-1:0]  cfg_data_i   = '0;

  // model state
  logic [CELL_W-1:0]  screen_mem [CELLS];
  int                 cur_col;
  int                 cur_row;
  logic [COL_W-1:0]   reg_cols;
  logic [ROW_W-1:0]   reg_rows;
  logic [CHAR_W-1:0]  reg_attr;

  res_t               console_results [$];
  res_t               head_result;
  int                 bad_results  = 0;
  int                 quiet_cycles = 0;
  int                 burst_left   = 0;
  bit                 gaps_on      = 1'b1;
  rx_style_e          rx_style     = RX_RANDOM;
  int                 rx_hold_req  = 0;
  int                 rx_hold_ack  = 0;
  int                 rx_hold_left = 0;
  logic [7:0]         rx_tick      = '0;

  text_console_char_engine_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_col_o      (out_col_o),
    .out_row_o      (out_row_o),
    .cursor_index_o (cursor_index_o),
    .cell_char_o    (cell_char_o),
    .cell_attr_o    (cell_attr_o),
    .scrolled_o     (scrolled_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int used_cols();
    if (reg_cols == '0) return 1;
    return (int'(reg_cols) > MAX_COLS) ? MAX_COLS : int'(reg_cols);
  endfunction

  function automatic int used_rows();
    if (reg_rows == '0) return 1;
    return (int'(reg_rows) > MAX_ROWS) ? MAX_ROWS : int'(reg_rows);
  endfunction

  function automatic void scroll_screen(int nc, int nr);
    int i;
    for (i = 0; i < nc * (nr - 1); i++) screen_mem[i] = screen_mem[i + nc];
    for (i = nc * (nr - 1); i < nc * nr; i++) screen_mem[i] = {reg_attr, CH_SPACE};
    cur_col = 0;
    cur_row = nr - 1;
  endfunction

  function automatic bit put_glyph(logic [CHAR_W-1:0] ch, int nc, int nr);
    screen_mem[cur_row * nc + cur_col] = {reg_attr, ch};
    cur_col++;
    if (cur_col >= nc) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= nr) begin
        scroll_screen(nc, nr);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t console_step(logic [1:0] m, logic [CHAR_W-1:0] ch,
                                        logic [IDX_W-1:0] cidx);
    res_t r;
    int   nc;
    int   nr;
    int   n;
    int   k;
    r  = '0;
    nc = used_cols();
    nr = used_rows();
    if (cur_col >= nc) cur_col = nc - 1;
    if (cur_row >= nr) cur_row = nr - 1;
    case (m)
      MODE_PUT: begin
        if (ch == CH_LF) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= nr) begin
            scroll_screen(nc, nr);
            r.scrolled = 1'b1;
          end
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_TAB) begin
          n = TAB_W - (cur_col % TAB_W);
          for (k = 0; k < n; k++)
            if (put_glyph(CH_SPACE, nc, nr)) r.scrolled = 1'b1;
        end else if (ch == CH_BS) begin
          if (cur_col != 0) begin
            cur_col--;
            screen_mem[cur_row * nc + cur_col] = {reg_attr, CH_SPACE};
          end
        end else begin
          r.scrolled = put_glyph(ch, nc, nr);
        end
      end
      MODE_READ: begin
        if (cidx < nc * nr) begin
          r.cell_char = screen_mem[cidx][7:0];
          r.cell_attr = screen_mem[cidx][15:8];
        end
      end
      MODE_CLEAR: begin
        for (k = 0; k < nc * nr; k++) screen_mem[k] = {reg_attr, CH_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    r.col = COL_W'(cur_col);
    r.row = ROW_W'(cur_row);
    r.idx = IDX_W'(cur_row * nc + cur_col);
    return r;
  endfunction

  task automatic offer_item(input logic [1:0] m, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] cidx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    char_code_i  <= ch;
    cell_index_i <= cidx;
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);
    console_results.push_back(console_step(m, ch, cidx));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CHAR_W-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    case (idx)
      CFG_COLUMNS: reg_cols = data[COL_W-1:0];
      CFG_ROWS:    reg_rows = data[ROW_W-1:0];
      CFG_ATTR:    reg_attr = data;
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] cols, input logic [7:0] rows,
                               input logic [7:0] attr);
    write_reg(CFG_COLUMNS, cols, 1'b0);
    write_reg(CFG_ROWS, rows, 1'b0);
    write_reg(CFG_ATTR, attr, 1'b1);
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (console_results.size() != 0);
  endtask

  task automatic test_control_codes();
    offer_item(MODE_PUT, 8'h48, 11'd0);
    offer_item(MODE_PUT, 8'hff, 11'h7ff);
    offer_item(MODE_PUT, 8'h00, 11'd0);
    offer_item(MODE_PUT, CH_BS, 11'd0);
    offer_item(MODE_PUT, CH_TAB, 11'd0);
    offer_item(MODE_PUT, CH_CR, 11'd0);
    offer_item(MODE_PUT, CH_BS, 11'd0);
    offer_item(MODE_PUT, CH_LF, 11'd0);
    offer_item(MODE_READ, 8'd0, 11'd0);
    offer_item(MODE_READ, 8'd0, 11'd1);
    offer_item(MODE_READ, 8'd0, 11'd2);
    offer_item(MODE_READ, 8'd0, 11'd1999);
    offer_item(MODE_READ, 8'd0, 11'h7ff);
    offer_item(MODE_UNUSED, 8'hff, 11'h7ff);
    offer_item(MODE_CLEAR, 8'd0, 11'd0);
    finish_phase();
  endtask

  task automatic test_geometry_edges();
    // a single cell: every glyph scrolls
    apply_setting(8'd0, 8'd0, 8'h00);
    offer_item(MODE_PUT, 8'h78, 11'd0);
    offer_item(MODE_PUT, CH_TAB, 11'd0);
    offer_item(MODE_PUT, CH_LF, 11'd0);
    offer_item(MODE_READ, 8'd0, 11'd0);
    finish_phase();
    apply_setting(8'd8, 8'd2, 8'h0f);
    offer_item(MODE_PUT, CH_LF, 11'd0);
    offer_item(MODE_PUT, 8'h41, 11'd0);
    offer_item(MODE_PUT, CH_BS, 11'd0);
    offer_item(MODE_PUT, 8'h41, 11'd0);
    offer_item(MODE_PUT, CH_TAB, 11'd0);
    offer_item(MODE_READ, 8'd0, 11'd15);
    finish_phase();
    // cursor left outside the new area
    apply_setting(8'd1, 8'd1, 8'h0e);
    offer_item(MODE_PUT, CH_BS, 11'd0);
    offer_item(MODE_READ, 8'd0, 11'd1);
    finish_phase();
    apply_setting(8'(RESET_COLS), 8'(RESET_ROWS), RESET_ATTR);
  endtask

  task automatic test_output_stall();
    int n;
    rx_style = RX_ALWAYS;
    gaps_on  = 1'b0;
    rx_hold_req++;
    for (n = 0; n < STALL_ITEMS; n++)
      offer_item(MODE_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
    finish_phase();
  endtask

  task automatic test_random_text();
    int         phase;
    int         n;
    int         pick;
    int         nc;
    int         nr;
    logic [7:0] col_data;
    logic [7:0] row_data;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          col_data = 8'd80;
          row_data = 8'd25;
        end
        1: begin
          col_data = 8'hff;
          row_data = 8'hff;
        end
        2: begin
          col_data = 8'h80;
          row_data = 8'd3;
        end
        default: begin
          col_data = 8'($urandom_range(1, 20));
          row_data = 8'($urandom_range(1, 6));
          if ($urandom_range(0, 3) == 0) col_data[7] = 1'b1;
        end
      endcase
      if (phase == 2) write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
      apply_setting(col_data, row_data, 8'($urandom_range(0, 255)));
      gaps_on  = (phase % 3) != 2;
      rx_style = rx_style_e'(phase % 3);
      nc = used_cols();
      nr = used_rows();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          offer_item(MODE_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        else if (pick < 68)
          offer_item(MODE_PUT, CH_LF, 11'($urandom_range(0, 2047)));
        else if (pick < 72)
          offer_item(MODE_PUT, CH_CR, 11'($urandom_range(0, 2047)));
        else if (pick < 77)
          offer_item(MODE_PUT, CH_TAB, 11'($urandom_range(0, 2047)));
        else if (pick < 82)
          offer_item(MODE_PUT, CH_BS, 11'($urandom_range(0, 2047)));
        else if (pick < 93)
          offer_item(MODE_READ, 8'($urandom_range(0, 255)),
                     11'($urandom_range(0, nc * nr - 1)));
        else if (pick < 95)
          offer_item(MODE_READ, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        else if (pick < 98)
          offer_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        else
          offer_item(MODE_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end
      finish_phase();
    end
  endtask

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      bad_results++;
      if (bad_results <= 50)
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  // result side stalls on its own pattern, plus one long hold when asked
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 8'd1;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold_left != 0) begin
      out_ready_i  <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_ack != rx_hold_req) begin
      rx_hold_ack  <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      out_ready_i  <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:   out_ready_i <= (rx_tick[2:0] != 3'd5) && (rx_tick[5:3] != 3'd6);
      endcase
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (console_results.size() == 0) begin
        bad_results++;
        $display("%0t: unexpected result: expected none got col %0d row %0d", $time,
                 out_col_o, out_row_o);
      end else begin
        head_result = console_results.pop_front();
        check_field("cursor column", 16'(head_result.col), 16'(out_col_o));
        check_field("cursor row", 16'(head_result.row), 16'(out_row_o));
        check_field("cursor index", 16'(head_result.idx), 16'(cursor_index_o));
        check_field("cell char", 16'(head_result.cell_char), 16'(cell_char_o));
        check_field("cell attribute", 16'(head_result.cell_attr), 16'(cell_attr_o));
        check_field("scrolled", 16'(head_result.scrolled), 16'(scrolled_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i) || (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("text_console_char_engine_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_mem[i] = RESET_CELL;
    cur_col  = 0;
    cur_row  = 0;
    reg_cols = RESET_COLS;
    reg_rows = RESET_ROWS;
    reg_attr = RESET_ATTR;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_control_codes();
    test_geometry_edges();
    test_output_stall();
    test_random_text();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (bad_results == 0 && console_results.size() == 0)
      $display("text_console_char_engine_unit verification clean");
    else
      $display("text_console_char_engine_unit verification failed");
    $finish;
  end

endmodule
